// ----- src/aled_pkg.sv -----
// Shared types and constants for the addressable LED SPI encoder.
// Used by the controller, the datapath and the top level; depends on nothing.
package aled_pkg;

    // Input stream layout
    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 8;
    localparam int OUT_USER_W = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_CODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_CODE  = 2'd2;

    localparam logic [8:0] LED_COUNT_RST = 9'd256;
    localparam logic [7:0] HIGH_CODE_RST = 8'd248;
    localparam logic [7:0] LOW_CODE_RST  = 8'd192;

    // Commands
    localparam logic [2:0] CMD_SET_ONE = 3'd0;
    localparam logic [2:0] CMD_SET_ALL = 3'd1;
    localparam logic [2:0] CMD_CLEAR   = 3'd2;
    localparam logic [2:0] CMD_START   = 3'd3;
    localparam logic [2:0] CMD_NEXT    = 3'd4;

    localparam int         COLOR_W  = 24;
    localparam logic [4:0] LAST_BIT = 5'd23;

    // Controller to datapath
    typedef struct packed {
        logic capture;      // latch the input request
        logic mul_en;       // register channel * alpha products
        logic res_clear;    // start a fresh result
        logic set_one;      // write one LED if index in range
        logic fill_init;    // reset the sweep counter
        logic fill_wr;      // write one sweep entry and advance
        logic fill_zero;    // sweep writes black
        logic start_frame;
        logic end_frame;
        logic rd_issue;     // read the store at the LED cursor
        logic emit;         // form the SPI byte, advance cursors
        logic out_load;     // move result into the output register
    } aled_ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       frame_active;
        logic       cursor_end;   // LED cursor at or beyond count
        logic       fill_last;    // sweep at count - 1
        logic       wipe_last;    // sweep at MAX_LEDS - 1
        logic       out_free;
    } aled_sts_t;

endpackage

// ----- src/aled_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module aled_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- src/aled_ctrl.sv -----
// Controller state machine of the LED SPI encoder.
// Uses aled_pkg for command codes and the control/status structs.
module aled_ctrl import aled_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  aled_sts_t sts,
    output aled_ctl_t ctl
);

    typedef enum logic [6:0] {
        ST_WIPE = 7'b0000001,
        ST_IDLE = 7'b0000010,
        ST_MUL  = 7'b0000100,
        ST_EXEC = 7'b0001000,
        ST_FILL = 7'b0010000,
        ST_READ = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WIPE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_WIPE:
            begin
                ctl.fill_wr   = 1'b1;
                ctl.fill_zero = 1'b1;
                if (sts.wipe_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                ctl.mul_en = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                ctl.res_clear = 1'b1;
                state_next    = ST_DONE;
                unique case (sts.cmd) inside
                    CMD_SET_ONE:
                    begin
                        ctl.set_one = 1'b1;
                    end
                    CMD_SET_ALL, CMD_CLEAR:
                    begin
                        ctl.fill_init = 1'b1;
                        state_next    = ST_FILL;
                    end
                    CMD_START:
                    begin
                        ctl.start_frame = 1'b1;
                    end
                    CMD_NEXT:
                    begin
                        if (sts.frame_active && sts.cursor_end)
                        begin
                            ctl.end_frame = 1'b1;
                        end
                        else if (sts.frame_active)
                        begin
                            ctl.rd_issue = 1'b1;
                            state_next   = ST_READ;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_FILL:
            begin
                ctl.fill_wr   = 1'b1;
                ctl.fill_zero = (sts.cmd != CMD_SET_ALL);
                if (sts.fill_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                ctl.emit   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/aled_datapath.sv -----
// Datapath of the LED SPI encoder: config registers, alpha scaling, frame store,
// sweep counter, frame cursors and output register. Uses aled_pkg and aled_ram.
module aled_datapath import aled_pkg::*; #(
    parameter int MAX_LEDS = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  in_tdata,
    input  logic [IN_USER_W-1:0]  in_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  aled_ctl_t             ctl,
    output aled_sts_t             sts,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_tdata,
    output logic [OUT_USER_W-1:0] out_tuser,
    output logic                  out_tlast
);

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int NW = $clog2(MAX_LEDS + 1);

    // floor(p / 255) for p up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] s;
        s = 17'(p) + 17'(p[15:8]) + 17'd1;
        return s[15:8];
    endfunction

    logic [8:0]   led_count_reg;
    logic [7:0]   high_code_reg;
    logic [7:0]   low_code_reg;

    logic [2:0]   cmd_reg;
    logic [9:0]   idx_reg;
    logic [7:0]   red_reg, green_reg, blue_reg, alpha_reg;
    logic [15:0]  prod_r_reg, prod_g_reg, prod_b_reg;

    logic [NW-1:0] fill_cnt_reg;
    logic [AW-1:0] led_cur_reg;
    logic [4:0]    bit_cur_reg;
    logic          frame_active_reg;

    logic [7:0]   res_byte_reg;
    logic         res_bvalid_reg, res_last_reg, res_err_reg;

    logic         out_valid_reg;
    logic [7:0]   out_byte_reg;
    logic         out_bvalid_reg, out_last_reg, out_err_reg;

    logic [10:0]       n11;
    logic              idx_ok;
    logic              led_last;
    logic [COLOR_W-1:0] color;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [COLOR_W-1:0] ram_wdata;
    logic [COLOR_W-1:0] ram_rdata;
    logic              cur_bit;

    // effective LED count: 0 acts as 1, clipped to MAX_LEDS
    always_comb
    begin
        if (led_count_reg == 9'd0)
        begin
            n11 = 11'd1;
        end
        else if ({2'b00, led_count_reg} > 11'(MAX_LEDS))
        begin
            n11 = 11'(MAX_LEDS);
        end
        else
        begin
            n11 = {2'b00, led_count_reg};
        end
    end

    assign idx_ok   = ({1'b0, idx_reg} < n11);
    assign led_last = ((11'(led_cur_reg) + 11'd1) >= n11);
    assign color    = {div255(prod_g_reg), div255(prod_r_reg), div255(prod_b_reg)};
    assign cur_bit  = ram_rdata[LAST_BIT - bit_cur_reg];

    assign sts.cmd          = cmd_reg;
    assign sts.frame_active = frame_active_reg;
    assign sts.cursor_end   = (11'(led_cur_reg) >= n11);
    assign sts.fill_last    = (11'(fill_cnt_reg) == (n11 - 11'd1));
    assign sts.wipe_last    = (fill_cnt_reg == NW'(MAX_LEDS - 1));
    assign sts.out_free     = !out_valid_reg || out_ready;

    // store write port: sweep has priority, else set one LED
    assign ram_we    = ctl.fill_wr || (ctl.set_one && idx_ok);
    assign ram_waddr = ctl.fill_wr ? fill_cnt_reg[AW-1:0] : idx_reg[AW-1:0];
    assign ram_wdata = (ctl.fill_wr && ctl.fill_zero) ? '0 : color;

    aled_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (MAX_LEDS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ctl.rd_issue),
        .rd_addr (led_cur_reg),
        .rd_data (ram_rdata)
    );

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg <= LED_COUNT_RST;
            high_code_reg <= HIGH_CODE_RST;
            low_code_reg  <= LOW_CODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_LED_COUNT: led_count_reg <= cfg_wdata;
                REG_HIGH_CODE: high_code_reg <= cfg_wdata[7:0];
                REG_LOW_CODE:  low_code_reg  <= cfg_wdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // request capture and scaling products
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg   <= in_tuser;
            idx_reg   <= in_tdata[9:0];
            red_reg   <= in_tdata[17:10];
            green_reg <= in_tdata[25:18];
            blue_reg  <= in_tdata[33:26];
            alpha_reg <= in_tdata[41:34];
        end
        if (ctl.mul_en)
        begin
            prod_r_reg <= 16'(red_reg) * 16'(alpha_reg);
            prod_g_reg <= 16'(green_reg) * 16'(alpha_reg);
            prod_b_reg <= 16'(blue_reg) * 16'(alpha_reg);
        end
    end

    // sweep counter and frame cursors
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg     <= '0;
            led_cur_reg      <= '0;
            bit_cur_reg      <= '0;
            frame_active_reg <= 1'b0;
        end
        else
        begin
            if (ctl.fill_init)
            begin
                fill_cnt_reg <= '0;
            end
            else if (ctl.fill_wr)
            begin
                fill_cnt_reg <= fill_cnt_reg + NW'(1);
            end

            if (ctl.start_frame)
            begin
                led_cur_reg      <= '0;
                bit_cur_reg      <= '0;
                frame_active_reg <= 1'b1;
            end
            else if (ctl.end_frame)
            begin
                frame_active_reg <= 1'b0;
            end
            else if (ctl.emit)
            begin
                if (bit_cur_reg >= LAST_BIT)
                begin
                    bit_cur_reg <= '0;
                    if (led_last)
                    begin
                        frame_active_reg <= 1'b0;
                        led_cur_reg      <= '0;
                    end
                    else
                    begin
                        led_cur_reg <= led_cur_reg + AW'(1);
                    end
                end
                else
                begin
                    bit_cur_reg <= bit_cur_reg + 5'd1;
                end
            end
        end
    end

    // pending result
    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            res_byte_reg   <= cur_bit ? high_code_reg : low_code_reg;
            res_bvalid_reg <= 1'b1;
            res_last_reg   <= (bit_cur_reg >= LAST_BIT) && led_last;
        end
        else if (ctl.res_clear)
        begin
            res_byte_reg   <= '0;
            res_bvalid_reg <= 1'b0;
            res_last_reg   <= 1'b0;
            res_err_reg    <= ctl.set_one && !idx_ok;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_byte_reg   <= res_byte_reg;
            out_bvalid_reg <= res_bvalid_reg;
            out_last_reg   <= res_last_reg;
            out_err_reg    <= res_err_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tdata = out_byte_reg;
    assign out_tuser = {out_err_reg, out_bvalid_reg};
    assign out_tlast = out_last_reg;

    // sweep stays inside the store
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fill_wr |-> (11'(fill_cnt_reg) < 11'(MAX_LEDS)))
        else $error("sweep address beyond store depth");

    // a byte is only formed inside a running frame
    a_emit_active: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> (frame_active_reg && (11'(led_cur_reg) < n11)))
        else $error("byte formed outside a frame");

    // frame end only on a real byte
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> out_bvalid_reg)
        else $error("last byte flag without byte");

    // one request in work at a time
    a_one_capture: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.capture |=> !ctl.capture)
        else $error("request captured while busy");

endmodule

// ----- src/addressable_led_spi_encoder.sv -----
// Addressable LED SPI encoder, top level.
// Ties together aled_ctrl and aled_datapath; uses aled_pkg.

// The block holds one 24-bit green-red-blue color per LED (MAX_LEDS entries in
// a RAM) and serves SPI bytes for a frame. Each request carries a command in
// tuser; colors are scaled to floor(channel*alpha/255) on the way in. Requests
// are taken one at a time: each passes through the accept, multiply and execute
// steps and hands its result to the output register before the next is taken;
// a next-byte request that sends a byte adds a step for the registered store read,
// set all and clear add a sweep over the effective LED count (one store write
// per cycle; a count of 0 acts as 1, a count above MAX_LEDS as MAX_LEDS). A result
// held in the output register does not block accepting the next request, but
// that request's result waits until the held one is taken.
// Every request gives exactly one result on the master side.
// After reset a clearing pass writes black into all MAX_LEDS entries, one per
// cycle, before the first request is taken; config writes are taken during it.
// Config registers (led_count, high_code, low_code) must be written while idle.
module addressable_led_spi_encoder import aled_pkg::*; #(
    parameter int MAX_LEDS = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // index[9:0], red[17:10], green[25:18], blue[33:26], alpha[41:34], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // cmd[2:0]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // spi_byte[7:0]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // byte_valid[0], index_error[1]
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    // last_byte
    output logic                  m_axis_tlast,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    aled_ctl_t ctl;
    aled_sts_t sts;

    // sequencing: accept, multiply, execute/sweep/read, hand off
    aled_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // store, cursors, scaling and output register
    aled_datapath #(
        .MAX_LEDS (MAX_LEDS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tdata  (s_axis_tdata),
        .in_tuser  (s_axis_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl),
        .sts       (sts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_tdata (m_axis_tdata),
        .out_tuser (m_axis_tuser),
        .out_tlast (m_axis_tlast)
    );

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for addressable_led_spi_encoder: a directed plan, then random frames.
// Depends on aled_pkg and the encoder RTL; predicts every SPI byte with its own LED store model.
module tb import aled_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEDS         = 256;
    localparam int IDLE_LIMIT   = 5000;   // cycles with no handshake on either side
    localparam int STALL_LEN    = 400;    // long receiver hold-off
    localparam int DRAIN_CYCLES = 300;    // covers a set-all sweep over 256 LEDs
    localparam int PHASES       = 6;

    // Commands the block must ignore
    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    // Register index past the end of the list, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [2:0] cmd;
        logic [9:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } led_req_t;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       byte_valid;
        logic       last_byte;
        logic       index_error;
    } led_rsp_t;

    // One line of the directed plan; fixed_rsp is used only where has_fixed is set
    typedef struct {
        led_req_t req;
        bit       has_fixed;
        led_rsp_t fixed_rsp;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // index[9:0], red[17:10], green[25:18], blue[33:26], alpha[41:34], zero pad
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // cmd[2:0]
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // spi_byte[7:0]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // byte_valid[0], index_error[1]
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Predictor state: LED colors as G,R,B and the frame cursors
    logic [23:0] pixel_mem [LEDS];
    int          tx_led;
    int          tx_bit;
    bit          tx_busy;
    logic [8:0]  cfg_count;
    logic [7:0]  cfg_hi;
    logic [7:0]  cfg_lo;

    led_rsp_t    due_bytes[$];    // responses still owed by the block, oldest first
    plan_row_t   plan[$];
    int          mismatches = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    bit          stall_req = 1'b0;

    addressable_led_spi_encoder #(.MAX_LEDS(LEDS)) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    // Count register as the block uses it: 0 acts as 1, anything past the store as the store size
    function automatic int eff_count();
        if (cfg_count == 9'd0)
            return 1;
        if (cfg_count > LEDS)
            return LEDS;
        return int'(cfg_count);
    endfunction

    // floor(c * a / 255)
    function automatic logic [7:0] dim(input logic [7:0] c, input logic [7:0] a);
        logic [15:0] prod;
        prod = c * a;
        return 8'(prod / 16'd255);
    endfunction

    // Applies one request to the model and returns the response it must produce
    function automatic led_rsp_t predict_spi(input led_req_t r);
        led_rsp_t   o;
        int         n;
        logic [23:0] grb;
        o   = '0;
        n   = eff_count();
        grb = {dim(r.green, r.alpha), dim(r.red, r.alpha), dim(r.blue, r.alpha)};
        case (r.cmd)
            CMD_SET_ONE:
            begin
                if (r.index < n)
                    pixel_mem[r.index] = grb;
                else
                    o.index_error = 1'b1;
            end
            CMD_SET_ALL:
                for (int i = 0; i < n; i++)
                    pixel_mem[i] = grb;
            CMD_CLEAR:
                for (int i = 0; i < n; i++)
                    pixel_mem[i] = '0;
            CMD_START:
            begin
                tx_led  = 0;
                tx_bit  = 0;
                tx_busy = 1'b1;
            end
            CMD_NEXT:
            begin
                if (tx_busy && tx_led >= n)
                    tx_busy = 1'b0;     // count shrank under a running frame
                else if (tx_busy)
                begin
                    // codes are picked up at send time, colors read live
                    o.spi_byte   = pixel_mem[tx_led][23 - tx_bit] ? cfg_hi : cfg_lo;
                    o.byte_valid = 1'b1;
                    if (tx_bit >= int'(LAST_BIT))
                    begin
                        tx_bit = 0;
                        if (tx_led + 1 >= n)
                        begin
                            o.last_byte = 1'b1;
                            tx_busy     = 1'b0;
                            tx_led      = 0;
                        end
                        else
                            tx_led++;
                    end
                    else
                        tx_bit++;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    // ---------------------------------------------------------------- request side

    // Offers one request, with random idle cycles first; logs the owed response on accept.
    // tvalid stays high on return so back-to-back requests need no extra assignment.
    task automatic send_request(input led_req_t r, input bit has_fixed, input led_rsp_t fixed_rsp);
        led_rsp_t p;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.cmd;
        s_axis_tdata  <= {6'b0, r.alpha, r.blue, r.green, r.red, r.index};
        do
            @(posedge clk);
        while (!s_axis_tready);
        p = predict_spi(r);
        due_bytes.push_back(has_fixed ? fixed_rsp : p);
    endtask

    task automatic plan_row(input logic [2:0] c, input logic [9:0] idx, input logic [31:0] rgba,
                            input bit has_fixed, input led_rsp_t rsp);
        plan_row_t row;
        row.req       = {c, idx, rgba};
        row.has_fixed = has_fixed;
        row.fixed_rsp = rsp;
        plan.push_back(row);
    endtask

    // Channel values lean on the extremes
    function automatic logic [7:0] rand_chan();
        case ($urandom_range(3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic led_req_t rand_req(input logic [2:0] c);
        led_req_t r;
        r.cmd   = c;
        r.index = 10'($urandom_range(1023));
        r.red   = rand_chan();
        r.green = rand_chan();
        r.blue  = rand_chan();
        r.alpha = rand_chan();
        return r;
    endfunction

    // Drops tvalid and waits until every owed response is back
    task automatic drain_responses();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (due_bytes.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= d;
        @(posedge clk);
        case (a)
            REG_LED_COUNT: cfg_count = d;
            REG_HIGH_CODE: cfg_hi    = d[7:0];
            REG_LOW_CODE:  cfg_lo    = d[7:0];
            default: ;
        endcase
    endtask

    // Registers change only with the block idle
    task automatic reconfigure(input logic [8:0] count, input logic [8:0] hi, input logic [8:0] lo);
        drain_responses();
        repeat (8) @(posedge clk);
        write_reg(REG_LED_COUNT, count);
        write_reg(REG_HIGH_CODE, hi);
        write_reg(REG_LOW_CODE, lo);
        write_reg(REG_UNUSED, 9'($urandom_range(511)));
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed frames (start, then a run of next-byte requests, sometimes
    // cut short or run past the end, with LED writes mixed in), the rest loose commands.
    task automatic random_phase(input int quota);
        int       done;
        int       pick;
        int       nbytes;
        led_req_t r;
        done = 0;
        while (done < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                send_request(rand_req(CMD_START), 1'b0, '0);
                done++;
                nbytes = 24 * eff_count() + $urandom_range(3);
                if (nbytes > 150)
                    nbytes = $urandom_range(150, 20);
                if ($urandom_range(4) == 0)
                    nbytes = $urandom_range(nbytes, 1);
                // keep the phase near its quota
                if (nbytes > quota - done)
                    nbytes = quota - done;
                repeat (nbytes)
                begin
                    if ($urandom_range(19) == 0)
                    begin
                        r = rand_req(CMD_SET_ONE);
                        r.index = 10'($urandom_range(eff_count() - 1));
                        send_request(r, 1'b0, '0);
                        done++;
                    end
                    send_request(rand_req(CMD_NEXT), 1'b0, '0);
                    done++;
                end
            end
            else if (pick < 70)
            begin
                r = rand_req(CMD_SET_ONE);
                if ($urandom_range(3) != 0)
                    r.index = 10'($urandom_range(eff_count() - 1));
                send_request(r, 1'b0, '0);
                done++;
            end
            else if (pick < 77)
            begin
                send_request(rand_req(CMD_SET_ALL), 1'b0, '0);
                done++;
            end
            else if (pick < 81)
            begin
                send_request(rand_req(CMD_CLEAR), 1'b0, '0);
                done++;
            end
            else if (pick < 88)
            begin
                send_request(rand_req(CMD_NEXT), 1'b0, '0);
                done++;
            end
            else
            begin
                // any command code, spare ones included; those do not count
                r = rand_req(3'($urandom_range(7)));
                send_request(r, 1'b0, '0);
                if (r.cmd <= CMD_NEXT)
                    done++;
            end
        end
    endtask

    // ---------------------------------------------------------------- result side

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("tb: mismatch at %0t: %s", $realtime, msg);
    endtask

    // Receiver: random tready, plus one long hold-off when asked for
    initial
    begin : rx_side
        bit stall_served;
        stall_served = 1'b0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_req && !stall_served)
            begin
                stall_served = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (STALL_LEN) @(posedge clk);
            end
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compares each accepted response with the oldest one owed
    initial
    begin : rsp_check
        led_rsp_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (due_bytes.size() == 0)
                    report_mismatch($sformatf("response with none owed, byte %0d", m_axis_tdata));
                else
                begin
                    want = due_bytes.pop_front();
                    if (m_axis_tdata !== want.spi_byte)
                        report_mismatch($sformatf("spi_byte %0d, want %0d",
                                                  m_axis_tdata, want.spi_byte));
                    if (m_axis_tuser[0] !== want.byte_valid)
                        report_mismatch($sformatf("byte_valid %b, want %b",
                                                  m_axis_tuser[0], want.byte_valid));
                    if (m_axis_tlast !== want.last_byte)
                        report_mismatch($sformatf("last_byte %b, want %b",
                                                  m_axis_tlast, want.last_byte));
                    if (m_axis_tuser[1] !== want.index_error)
                        report_mismatch($sformatf("index_error %b, want %b",
                                                  m_axis_tuser[1], want.index_error));
                end
            end
        end
    end

    // Watchdog: too long without any handshake ends the run
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial
    begin : stimulus
        logic [8:0] counts [PHASES];
        logic [8:0] hi;
        logic [8:0] lo;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        cfg_we        <= 1'b0;
        cfg_addr      <= '0;
        cfg_wdata     <= '0;

        // model state after reset: store dark, no frame, register defaults
        foreach (pixel_mem[i])
            pixel_mem[i] = '0;
        tx_led    = 0;
        tx_bit    = 0;
        tx_busy   = 1'b0;
        cfg_count = LED_COUNT_RST;
        cfg_hi    = HIGH_CODE_RST;
        cfg_lo    = LOW_CODE_RST;

        // Directed plan, run with the reset register values (256 LEDs, codes 248/192).
        // Response layout: {spi_byte, byte_valid, last_byte, index_error}; rgba = {r, g, b, a}.
        plan_row(CMD_NEXT,    10'd0,    32'h0,          1, {8'd0, 3'b000});  // no frame yet
        plan_row(CMD_SPARE_5, 10'h3FF,  32'hFFFF_FFFF,  1, {8'd0, 3'b000});
        plan_row(CMD_SPARE_6, 10'h3FF,  32'hFFFF_FFFF,  1, {8'd0, 3'b000});
        plan_row(CMD_SPARE_7, 10'h3FF,  32'hFFFF_FFFF,  1, {8'd0, 3'b000});
        plan_row(CMD_SET_ONE, 10'h3FF,  32'hFFFF_FFFF,  1, {8'd0, 3'b001});  // index far out
        plan_row(CMD_SET_ONE, 10'd256,  32'hFFFF_FFFF,  1, {8'd0, 3'b001});  // index == count
        plan_row(CMD_SET_ONE, 10'd255,  32'hFFFF_FFFF,  1, {8'd0, 3'b000});  // last LED
        plan_row(CMD_SET_ONE, 10'd0,    32'h0080_01FF,  1, {8'd0, 3'b000});  // green MSB set
        plan_row(CMD_START,   10'd0,    32'h0,          1, {8'd0, 3'b000});
        plan_row(CMD_NEXT,    10'd0,    32'h0,          1, {8'd248, 3'b100});
        plan_row(CMD_NEXT,    10'd0,    32'h0,          1, {8'd192, 3'b100});
        plan_row(CMD_SET_ONE, 10'd1,    32'hC864_3380,  1, {8'd0, 3'b000});  // half alpha
        plan_row(CMD_SET_ALL, 10'd0,    32'hFFFF_FFFE,  1, {8'd0, 3'b000});
        plan_row(CMD_NEXT,    10'd0,    32'h0,          0, '0);  // store read live mid frame
        plan_row(CMD_START,   10'd0,    32'h0,          1, {8'd0, 3'b000});  // restart
        plan_row(CMD_NEXT,    10'd0,    32'h0,          0, '0);
        plan_row(CMD_CLEAR,   10'd0,    32'hAA55_0FFF,  1, {8'd0, 3'b000});
        plan_row(CMD_NEXT,    10'd0,    32'h0,          1, {8'd192, 3'b100});
        plan_row(CMD_SET_ALL, 10'd7,    32'hFFFF_FF00,  1, {8'd0, 3'b000});  // alpha zero
        plan_row(CMD_NEXT,    10'd0,    32'h0,          0, '0);
        plan_row(CMD_SET_ONE, 10'd0,    32'hFFFF_FFFF,  1, {8'd0, 3'b000});
        plan_row(CMD_NEXT,    10'd0,    32'h0,          0, '0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            send_request(plan[i].req, plan[i].has_fixed, plan[i].fixed_rsp);

        // Count per phase: small, one, zero (acts as one), full, small, past the store
        counts = '{9'd5, 9'd1, 9'd0, 9'd256, 9'd3, 9'd511};
        for (int ph = 0; ph < PHASES; ph++)
        begin
            // sender light / receiver heavy idling, then swapped, then none
            tx_idle_pct = (ph < 2) ? 10 : (ph < 4) ? 87 : 0;
            rx_idle_pct = (ph < 2) ? 87 : (ph < 4) ? 10 : 0;
            hi = 9'($urandom_range(511));
            lo = 9'($urandom_range(511));
            if (ph == 1)
            begin
                hi = 9'd255;
                lo = 9'd0;
            end
            else if (ph == 2)
            begin
                hi = 9'd0;
                lo = 9'd255;
            end
            reconfigure(counts[ph], hi, lo);

            // frame left at LED 4 from the full-count phase; count is now 3, so it ends here
            if (ph == 4)
                send_request(rand_req(CMD_NEXT), 1'b0, '0);

            random_phase(155);
            if (ph == 0)
                stall_req = 1'b1;   // receiver holds off while requests keep coming
            if (ph == 2)
                drain_responses();  // sender waits for every owed response
            random_phase(155);

            if (ph == 3)
            begin
                send_request(rand_req(CMD_START), 1'b0, '0);
                repeat (24 * 4 + 2)
                    send_request(rand_req(CMD_NEXT), 1'b0, '0);
            end
        end

        drain_responses();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/aled_pkg.sv
src/aled_ram.sv
src/aled_ctrl.sv
src/aled_datapath.sv
src/addressable_led_spi_encoder.sv
tb/sv/tb.sv
